### design/text_console_char_writer_macros.svh
// Assertion macros for the console writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/tcw_pkg.sv
package tcw_pkg;
  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_MOVE  = 3'd1;
  localparam logic [2:0] REQ_SHOW  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_SCROLL  = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] COLOR_RESET = 8'd15;
  localparam logic [7:0] MARK_BIT = 8'h80;
endpackage

### design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/text_console_char_writer.sv
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | in_req_type in_char_code in_col in_row in_show_cursor
// result   | out_valid / out_ready | out_cursor_col out_cursor_row out_placed out_cell_*
// config   | cfg_we                | cfg_index cfg_wdata
// A request is worked by a sequencer around one shared adder (index math)
// and the two RAM read/write ports, one item at a time.
// Index math accumulates the columns row by row, then adds the column.
// Scroll moves each lower row up and zeroes the bottom row's chars; clear fills the grid.
// After reset a clearing pass fills all CELLS entries of the memories; no item is taken.
// The result is held in an output register until taken; in_ready is low meanwhile.
`include "text_console_char_writer_macros.svh"
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25,
  parameter int CELLS = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic       in_show_cursor,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_placed,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_color
);
  localparam int AW = $clog2(CELLS);
  localparam int CW = 7;
  localparam int RW = 5;
  localparam logic [CW-1:0] MAXC = (MAX_COLS > 127) ? CW'(127) : CW'(MAX_COLS);
  localparam logic [RW-1:0] MAXR = (MAX_ROWS > 31) ? RW'(31) : RW'(MAX_ROWS);

  typedef enum logic [14:0] {
    S_INIT   = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_UNMARK = 15'b000000000000100, // read cell under cursor
    S_UNMW   = 15'b000000000001000, // write it back toggled
    S_ACT    = 15'b000000000010000, // perform the action
    S_IDX    = 15'b000000000100000, // index = row*cols + col, one add per cycle
    S_SCRD   = 15'b000000001000000, // scroll read
    S_SCWR   = 15'b000000010000000, // scroll write
    S_SCBOT  = 15'b000000100000000, // zero bottom row
    S_CLR    = 15'b000001000000000,
    S_MARK   = 15'b000010000000000,
    S_MARKW  = 15'b000100000000000,
    S_RDWAIT = 15'b001000000000000,
    S_RDDONE = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  // What to do once the cell index is computed.
  typedef enum logic [2:0] {
    IX_MARK, IX_READ, IX_BSW, IX_WRITE
  } ixgoal_t;

  state_t state_r, state_nxt;
  ixgoal_t goal_r, goal_nxt;

  logic [CW-1:0] columns_r;
  logic [RW-1:0] rows_r;
  logic          scroll_r;
  logic [CW-1:0] ucols;
  logic [RW-1:0] urows;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] cidx_r, cidx_nxt;
  logic esc_r, esc_nxt, rev_r, rev_nxt, shown_r, shown_nxt;
  logic [3:0] fg_r, fg_nxt, bg_r, bg_nxt;

  logic [2:0] req_r, req_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic [CW-1:0] tc_r, tc_nxt;
  logic [RW-1:0] tr_r, tr_nxt;

  // Shared adder operands and iteration counters.
  logic [AW-1:0] acc_r, acc_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] add_a, add_b, add_y;
  logic [AW:0]   ncells;

  logic [7:0] o_char_r, o_char_nxt, o_col_r, o_col_nxt;
  logic o_placed_r, o_placed_nxt;

  logic ch_we, co_we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] ch_wd, co_wd, ch_rd, co_rd;

  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char (
    .clk(clk), .we(ch_we), .waddr(waddr), .wdata(ch_wd), .raddr(raddr), .rdata(ch_rd));
  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color (
    .clk(clk), .we(co_we), .waddr(waddr), .wdata(co_wd), .raddr(raddr), .rdata(co_rd));

  // Clamp the size registers to the usable range.
  always_comb begin
    ucols = (columns_r == '0) ? CW'(1) : ((columns_r > MAXC) ? MAXC : columns_r);
    urows = (rows_r == '0) ? RW'(1) : ((rows_r > MAXR) ? MAXR : rows_r);
  end

  assign add_y = add_a + add_b;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_placed = o_placed_r;
  assign out_cell_char = o_char_r;
  assign out_cell_color = o_col_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 7'd40;
      rows_r <= 5'd25;
      scroll_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: columns_r <= cfg_wdata;
        CFG_ROWS:    rows_r <= cfg_wdata[RW-1:0];
        CFG_SCROLL:  scroll_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    logic [CW-1:0] c1;
    c1 = col_r + CW'(1);
    state_nxt = state_r;
    goal_nxt = goal_r;
    col_nxt = col_r; row_nxt = row_r; cidx_nxt = cidx_r;
    esc_nxt = esc_r; rev_nxt = rev_r; shown_nxt = shown_r;
    fg_nxt = fg_r; bg_nxt = bg_r;
    req_nxt = req_r; ch_nxt = ch_r; tc_nxt = tc_r; tr_nxt = tr_r;
    acc_nxt = acc_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r; end_nxt = end_r;
    o_char_nxt = o_char_r; o_col_nxt = o_col_r; o_placed_nxt = o_placed_r;
    ch_we = 1'b0; co_we = 1'b0;
    waddr = cidx_r; raddr = cidx_r;
    ch_wd = ch_rd ^ MARK_BIT; co_wd = COLOR_RESET;
    add_a = acc_r; add_b = AW'(ucols);
    ncells = ((AW+1)'(ucols) * (AW+1)'(urows) > (AW+1)'(CELLS)) ? (AW+1)'(CELLS) :
             (AW+1)'(ucols) * (AW+1)'(urows);

    unique case (state_r)
      S_INIT: begin
        ch_we = 1'b1; co_we = 1'b1; waddr = ptr_r; ch_wd = CH_SPACE;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type; ch_nxt = in_char_code;
          tc_nxt = (in_col > ucols - CW'(1)) ? ucols - CW'(1) : in_col;
          tr_nxt = (in_row > urows - RW'(1)) ? urows - RW'(1) : in_row;
          o_char_nxt = '0; o_col_nxt = '0; o_placed_nxt = 1'b0;
          priority if (in_req_type == REQ_WRITE && esc_r) begin
            if (in_char_code == CH_UP_R) rev_nxt = 1'b1;
            else if (in_char_code == CH_LO_R) rev_nxt = 1'b0;
            else if (in_char_code == CH_UP_B) bg_nxt = 4'd2;
            else fg_nxt = in_char_code[3:0];
            esc_nxt = 1'b0; state_nxt = S_OUT;
          end else if (in_req_type == REQ_WRITE && in_char_code == CH_ESC) begin
            esc_nxt = 1'b1; state_nxt = S_OUT;
          end else if (in_req_type == REQ_WRITE || in_req_type == REQ_MOVE) begin
            o_placed_nxt = (in_req_type == REQ_WRITE);
            state_nxt = shown_r ? S_UNMARK : S_ACT;
          end else if (in_req_type == REQ_SHOW) begin
            shown_nxt = in_show_cursor;
            state_nxt = (shown_r != in_show_cursor) ? S_MARK : S_OUT;
            goal_nxt = IX_MARK;
          end else if (in_req_type == REQ_CLEAR) begin
            rev_nxt = 1'b0; fg_nxt = 4'd15; ptr_nxt = '0;
            end_nxt = AW'(ncells - (AW+1)'(1));
            state_nxt = S_CLR;
          end else if (in_req_type == REQ_READ) begin
            acc_nxt = '0; cnt_nxt = '0; goal_nxt = IX_READ; state_nxt = S_IDX;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_UNMARK: state_nxt = S_UNMW;
      S_UNMW: begin
        ch_we = 1'b1;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        acc_nxt = '0; cnt_nxt = '0; goal_nxt = IX_MARK;
        state_nxt = S_IDX;
        if (req_r == REQ_MOVE) begin
          col_nxt = tc_r; row_nxt = tr_r;
        end else if (ch_r == CH_LF) begin
          col_nxt = '0;
          if (32'(row_r) + 1 >= 32'(urows)) begin
            if (scroll_r) state_nxt = S_SCRD;
          end else row_nxt = row_r + RW'(1);
          ptr_nxt = '0; cnt_nxt = '0;
        end else if (ch_r == CH_CR) begin
          col_nxt = '0;
        end else if (ch_r == CH_BS) begin
          if (row_r != '0 || col_r != '0) begin
            goal_nxt = IX_BSW;
            if (col_r == '0) begin
              col_nxt = ucols - CW'(1); row_nxt = row_r - RW'(1);
            end else col_nxt = col_r - CW'(1);
          end
        end else begin
          // Printable: store at current index, then advance.
          ch_we = 1'b1; co_we = 1'b1;
          ch_wd = rev_r ? (ch_r | MARK_BIT) : (ch_r & ~MARK_BIT);
          co_wd = {bg_r, fg_r};
          col_nxt = c1;
          if (c1 >= ucols) begin
            col_nxt = '0;
            if (32'(row_r) + 1 >= 32'(urows)) begin
              if (scroll_r) state_nxt = S_SCRD;
            end else row_nxt = row_r + RW'(1);
            ptr_nxt = '0; cnt_nxt = '0;
          end
        end
      end
      S_SCRD: begin
        // ptr = destination; source is ptr + cols via the shared adder.
        add_a = ptr_r;
        raddr = add_y;
        end_nxt = AW'(32'(ucols) * (32'(urows) - 1));
        state_nxt = (urows == RW'(1)) ? S_SCBOT : S_SCWR;
        if (urows == RW'(1)) ptr_nxt = '0;
      end
      S_SCWR: begin
        ch_we = 1'b1; co_we = 1'b1; waddr = ptr_r; ch_wd = ch_rd; co_wd = co_rd;
        ptr_nxt = ptr_r + AW'(1);
        state_nxt = (ptr_r + AW'(1) == end_r) ? S_SCBOT : S_SCRD;
        cnt_nxt = '0;
      end
      S_SCBOT: begin
        // The bottom row ends at end + columns, found with the shared adder.
        add_a = end_r;
        ch_we = 1'b1; waddr = ptr_r; ch_wd = '0;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r + AW'(1) == add_y) begin
          acc_nxt = '0; cnt_nxt = '0; state_nxt = S_IDX;
        end
      end
      S_CLR: begin
        ch_we = 1'b1; co_we = 1'b1; waddr = ptr_r; ch_wd = CH_SPACE;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == end_r) begin
          col_nxt = '0; row_nxt = '0; acc_nxt = '0; cnt_nxt = '0;
          goal_nxt = IX_MARK; state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        // Accumulate one row of columns per cycle.
        if (goal_r == IX_READ) begin
          if (cnt_r == tr_r) begin
            add_b = AW'(tc_r); ptr_nxt = add_y; state_nxt = S_RDWAIT;
          end else begin
            acc_nxt = add_y; cnt_nxt = cnt_r + RW'(1);
          end
        end else if (cnt_r == row_r) begin
          add_b = AW'(col_r);
          cidx_nxt = add_y;
          if (goal_r == IX_BSW) begin
            state_nxt = S_MARK; goal_nxt = IX_WRITE;
          end else state_nxt = shown_r ? S_MARK : S_OUT;
        end else begin
          acc_nxt = add_y; cnt_nxt = cnt_r + RW'(1);
        end
      end
      S_MARK: begin
        if (goal_r == IX_WRITE) begin
          ch_we = 1'b1; ch_wd = '0;
          goal_nxt = IX_MARK;
          state_nxt = shown_r ? S_MARK : S_OUT;
        end else state_nxt = S_MARKW;
      end
      S_MARKW: begin
        ch_we = 1'b1;
        state_nxt = S_OUT;
      end
      S_RDWAIT: begin
        raddr = ptr_r;
        state_nxt = S_RDDONE;
      end
      S_RDDONE: begin
        o_char_nxt = ch_rd; o_col_nxt = co_rd;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      goal_r <= IX_MARK;
      col_r <= '0; row_r <= '0; cidx_r <= '0;
      esc_r <= 1'b0; rev_r <= 1'b0; shown_r <= 1'b0;
      fg_r <= 4'd15; bg_r <= 4'd0;
      ptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      goal_r <= goal_nxt;
      col_r <= col_nxt; row_r <= row_nxt; cidx_r <= cidx_nxt;
      esc_r <= esc_nxt; rev_r <= rev_nxt; shown_r <= shown_nxt;
      fg_r <= fg_nxt; bg_r <= bg_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; ch_r <= ch_nxt; tc_r <= tc_nxt; tr_r <= tr_nxt;
    acc_r <= acc_nxt; cnt_r <= cnt_nxt; end_r <= end_nxt;
    o_char_r <= o_char_nxt; o_col_r <= o_col_nxt; o_placed_r <= o_placed_nxt;
  end

  // Checks on the sequencer.
  `TCW_ASSERT_IMP(a_ready_excl, in_ready, !out_valid)
  `TCW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cursor_col))
  `TCW_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
endmodule

### tb/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int MAX_COLS = 80;
  localparam int MAX_ROWS = 25;
  localparam int CELLS = 2048;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic       show_cursor;
  } request_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       placed;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_COLUMNS;
  logic [6:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = REQ_WRITE;
  logic [7:0] in_char_code = '0;
  logic [6:0] in_col = '0;
  logic [4:0] in_row = '0;
  logic in_show_cursor = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic out_placed;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_color;

  text_console_char_writer u_top (.*);

  always #2 clk = ~clk;

  // Shadow copy of the console state.
  logic [7:0] sh_char [CELLS];
  logic [7:0] sh_color [CELLS];
  int unsigned sh_col, sh_row, sh_index;
  bit sh_escape, sh_reverse, sh_shown;
  int unsigned sh_fg, sh_bg;
  int unsigned sh_columns, sh_rows, sh_scroll;

  request_t pending_requests[$];
  response_t expected_responses[$];
  int unsigned error_count = 0;
  int unsigned accepted_requests = 0;
  int unsigned checked_responses = 0;
  int unsigned idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic int unsigned grid_cols();
    if (sh_columns == 0) return 1;
    return sh_columns > MAX_COLS ? MAX_COLS : sh_columns;
  endfunction

  function automatic int unsigned grid_rows();
    if (sh_rows == 0) return 1;
    return sh_rows > MAX_ROWS ? MAX_ROWS : sh_rows;
  endfunction

  function automatic int unsigned cell_at(int unsigned r, int unsigned c);
    return (r * grid_cols() + c) % CELLS;
  endfunction

  function automatic void flip_cursor_mark();
    if (sh_shown) sh_char[sh_index % CELLS] ^= MARK_BIT;
  endfunction

  function automatic void console_reset();
    for (int i = 0; i < CELLS; i++) begin
      sh_char[i] = CH_SPACE;
      sh_color[i] = COLOR_RESET;
    end
    sh_col = 0; sh_row = 0; sh_index = 0;
    sh_escape = 0; sh_reverse = 0; sh_shown = 0;
    sh_fg = 15; sh_bg = 0;
    sh_columns = 40; sh_rows = 25; sh_scroll = 1;
  endfunction

  function automatic void shift_rows_up();
    int unsigned w, h;
    w = grid_cols();
    h = grid_rows();
    if (sh_scroll == 0) return;
    for (int unsigned y = 0; y + 1 < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        sh_char[cell_at(y, x)] = sh_char[cell_at(y + 1, x)];
        sh_color[cell_at(y, x)] = sh_color[cell_at(y + 1, x)];
      end
    end
    for (int unsigned x = 0; x < w; x++) sh_char[cell_at(h - 1, x)] = 8'd0;
  endfunction

  function automatic void line_feed();
    if (sh_row + 1 >= grid_rows()) shift_rows_up();
    else sh_row++;
    sh_col = 0;
  endfunction

  function automatic void emit_byte(logic [7:0] c);
    flip_cursor_mark();
    if (c == CH_LF) begin
      line_feed();
    end else if (c == CH_CR) begin
      sh_col = 0;
    end else if (c == CH_BS) begin
      if (sh_row != 0 || sh_col != 0) begin
        if (sh_col == 0) begin
          sh_col = grid_cols() - 1;
          sh_row--;
        end else begin
          sh_col--;
        end
        sh_index = cell_at(sh_row, sh_col);
        sh_char[sh_index] = 8'd0;
      end
    end else begin
      sh_char[sh_index % CELLS] = sh_reverse ? (c | MARK_BIT) : (c & 8'h7F);
      sh_color[sh_index % CELLS] = 8'((sh_fg & 15) | ((sh_bg & 15) << 4));
      sh_col++;
      if (sh_col >= grid_cols()) line_feed();
    end
    sh_col &= 32'h7F;
    sh_row &= 32'h1F;
    sh_index = cell_at(sh_row, sh_col);
    flip_cursor_mark();
  endfunction

  // Apply one request to the shadow state and return the response it must give.
  function automatic response_t console_step(request_t rq);
    response_t rs;
    int unsigned tc, tr, n;
    rs = '0;
    tc = rq.col;
    tr = rq.row;
    if (tc > grid_cols() - 1) tc = grid_cols() - 1;
    if (tr > grid_rows() - 1) tr = grid_rows() - 1;
    case (rq.req_type)
      REQ_WRITE: begin
        if (sh_escape) begin
          if (rq.char_code == CH_UP_R) sh_reverse = 1;
          else if (rq.char_code == CH_LO_R) sh_reverse = 0;
          else if (rq.char_code == CH_UP_B) sh_bg = 2;
          else sh_fg = rq.char_code & 15;
          sh_escape = 0;
        end else if (rq.char_code == CH_ESC) begin
          sh_escape = 1;
        end else begin
          emit_byte(rq.char_code);
          rs.placed = 1'b1;
        end
      end
      REQ_MOVE: begin
        flip_cursor_mark();
        sh_col = tc;
        sh_row = tr;
        sh_index = cell_at(sh_row, sh_col);
        flip_cursor_mark();
      end
      REQ_SHOW: begin
        if (sh_shown != rq.show_cursor) sh_char[sh_index % CELLS] ^= MARK_BIT;
        sh_shown = rq.show_cursor;
      end
      REQ_CLEAR: begin
        n = grid_cols() * grid_rows();
        if (n > CELLS) n = CELLS;
        sh_reverse = 0;
        sh_fg = 15;
        for (int unsigned i = 0; i < n; i++) begin
          sh_char[i] = CH_SPACE;
          sh_color[i] = COLOR_RESET;
        end
        sh_col = 0;
        sh_row = 0;
        sh_index = 0;
        flip_cursor_mark();
      end
      REQ_READ: begin
        rs.cell_char = sh_char[cell_at(tr, tc)];
        rs.cell_color = sh_color[cell_at(tr, tc)];
      end
      default: ;
    endcase
    rs.cursor_col = 7'(sh_col);
    rs.cursor_row = 5'(sh_row);
    return rs;
  endfunction

  function automatic request_t make_request(logic [2:0] t, logic [7:0] c,
                                            logic [6:0] x, logic [4:0] y, logic s);
    request_t rq;
    rq.req_type = t;
    rq.char_code = c;
    rq.col = x;
    rq.row = y;
    rq.show_cursor = s;
    return rq;
  endfunction

  // Random request, weighted toward printable text and control bytes.
  function automatic request_t random_request();
    int unsigned pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    c = 8'($urandom);
    if (pick < 50) begin
      c = 8'($urandom_range(32, 126));
      if ($urandom_range(0, 3) == 0) c = 8'($urandom);
    end else if (pick < 56) c = CH_LF;
    else if (pick < 60) c = CH_CR;
    else if (pick < 65) c = CH_BS;
    else if (pick < 70) c = CH_ESC;
    if (pick < 70)
      return make_request(REQ_WRITE, c, 7'($urandom), 5'($urandom), 1'($urandom));
    if (pick < 80)
      return make_request(REQ_MOVE, c, 7'($urandom), 5'($urandom), 1'($urandom));
    if (pick < 85)
      return make_request(REQ_SHOW, c, 7'($urandom), 5'($urandom), 1'($urandom));
    if (pick < 86)
      return make_request(REQ_CLEAR, c, 7'($urandom), 5'($urandom), 1'($urandom));
    if (pick < 99)
      return make_request(REQ_READ, c, 7'($urandom), 5'($urandom), 1'($urandom));
    return make_request(3'($urandom_range(5, 7)), c, 7'($urandom), 5'($urandom),
                        1'($urandom));
  endfunction

  // Driver: offers queued items with random gaps, predicts each accepted one.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_responses.push_back(console_step(pending_requests.pop_front()));
        accepted_requests++;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && !(in_valid && in_ready &&
                     pending_requests.size() == 0)) begin
          in_valid <= 1'b1;
          {in_req_type, in_char_code, in_col, in_row, in_show_cursor} <=
            pending_requests[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compares each item with the oldest prediction.
  int unsigned recv_gap = 0;
  always @(posedge clk) begin
    response_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected result item col=%0d row=%0d", $time,
                   out_cursor_col, out_cursor_row);
          error_count++;
        end else begin
          want = expected_responses.pop_front();
          checked_responses++;
          if (want.cursor_col !== out_cursor_col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time,
                     want.cursor_col, out_cursor_col);
            error_count++;
          end
          if (want.cursor_row !== out_cursor_row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time,
                     want.cursor_row, out_cursor_row);
            error_count++;
          end
          if (want.placed !== out_placed) begin
            $display("%0t: placed expected %0d actual %0d", $time,
                     want.placed, out_placed);
            error_count++;
          end
          if (want.cell_char !== out_cell_char) begin
            $display("%0t: cell_char expected %h actual %h", $time,
                     want.cell_char, out_cell_char);
            error_count++;
          end
          if (want.cell_color !== out_cell_color) begin
            $display("%0t: cell_color expected %h actual %h", $time,
                     want.cell_color, out_cell_color);
            error_count++;
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || long_hold)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_char_writer_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_responses.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLUMNS: sh_columns = value & 32'h7F;
      CFG_ROWS: sh_rows = value & 32'h1F;
      CFG_SCROLL: sh_scroll = value & 1;
      default: ;
    endcase
  endtask

  task automatic run_phase(int unsigned cols, int unsigned rws, int unsigned scr,
                           int unsigned count);
    wait_drained();
    write_register(CFG_COLUMNS, cols);
    write_register(CFG_ROWS, rws);
    write_register(CFG_SCROLL, scr);
    for (int unsigned i = 0; i < count; i++) pending_requests.push_back(random_request());
  endtask

  initial begin
    console_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every request kind, escapes, control bytes and field extremes.
    pending_requests.push_back(make_request(REQ_READ, 8'h00, 7'h7F, 5'h1F, 1'b0));
    pending_requests.push_back(make_request(REQ_SHOW, 8'h00, 7'h00, 5'h00, 1'b1));
    pending_requests.push_back(make_request(REQ_WRITE, 8'hFF, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, 8'h00, 7'h7F, 5'h1F, 1'b1));
    pending_requests.push_back(make_request(REQ_WRITE, CH_ESC, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_UP_R, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, 8'h41, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_ESC, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_UP_B, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_ESC, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, 8'hA3, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_ESC, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_LO_R, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_BS, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_CR, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_MOVE, 8'h00, 7'h7F, 5'h1F, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, 8'h5A, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_LF, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_MOVE, 8'h00, 7'h00, 5'h01, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, CH_BS, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_READ, 8'h00, 7'h27, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_WRITE, 8'h00, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_CLEAR, 8'h00, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_UNKNOWN, 8'h00, 7'h00, 5'h00, 1'b0));
    pending_requests.push_back(make_request(REQ_READ, 8'h00, 7'h00, 5'h00, 1'b0));

    // Long receiver hold while the sender keeps offering, so the block backs up.
    wait_drained();
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) pending_requests.push_back(random_request());
    repeat (600) @(posedge clk);
    long_hold = 1'b0;

    // Random phases across register settings, extremes and out-of-range values.
    run_phase(8, 4, 1, 300);
    run_phase(1, 2, 1, 150);
    run_phase(0, 0, 1, 100);
    run_phase(80, 25, 0, 200);
    run_phase(127, 31, 1, 150);
    run_phase(13, 5, 0, 200);
    run_phase(5, 3, 1, 300);
    wait_drained();

    $display("Covered %0d requests, %0d result items checked over 8 register settings.",
             accepted_requests, checked_responses);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("text_console_char_writer_tb: PASS");
    end else begin
      $display("text_console_char_writer_tb: FAIL");
    end
    $finish;
  end

endmodule
